FILE: design/smt_pkg.sv
`timescale 1ns / 1ps

package smt_pkg;

	// Default number of set entries
	localparam int DEFAULT_CAPACITY = 16;

	// Operation codes
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_SEARCH = 2'd2;

	// Result status codes
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	// Request payload
	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [31:0] element;
	} req_t;

	// Response payload
	typedef struct packed {
		logic [1:0] status;
		logic [4:0] count;
		logic       empty_res;
	} rsp_t;

	// Controller states
	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_COMMIT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_req;
		logic scan_issue;
		logic clear_wr;
		logic commit;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic issue_done;
		logic rd_pend;
		logic out_free;
	} sts_t;

endpackage

FILE: design/smt_ram.sv
`timescale 1ns / 1ps

module smt_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

FILE: design/smt_ctrl.sv
`timescale 1ns / 1ps

module smt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  smt_pkg::sts_t sts,
	output smt_pkg::cmd_t cmd
);

	import smt_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				if (sts.issue_done) begin
					state_d = S_IDLE;
				end else begin
					cmd.clear_wr = 1'b1;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_SCAN;
				end
			end
			S_SCAN: begin
				if (!sts.issue_done) begin
					cmd.scan_issue = 1'b1;
				end else if (!sts.rd_pend) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

endmodule

FILE: design/smt_dp.sv
`timescale 1ns / 1ps

module smt_dp #(
	parameter int CAPACITY = smt_pkg::DEFAULT_CAPACITY
) (
	input  logic          clk,
	input  logic          arst_n,
	input  smt_pkg::req_t req,
	input  smt_pkg::cmd_t cmd,
	output smt_pkg::sts_t sts,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output smt_pkg::rsp_t rsp
);

	import smt_pkg::*;

	localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CWX  = (CW > 5) ? CW : 5;
	localparam int RW   = 33;

	req_t           req_q;
	logic [CW-1:0]  scan_cnt_q;
	logic           rd_vld_s1;
	logic [AW-1:0]  rd_idx_s1;
	logic           hit_q;
	logic [AW-1:0]  hit_idx_q;
	logic           free_found_q;
	logic [AW-1:0]  free_idx_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  count_d;
	logic           out_vld_q;
	rsp_t           rsp_q;
	logic [1:0]     status_d;
	logic [CWX-1:0] count_ext;

	logic           ram_we;
	logic [AW-1:0]  ram_addr;
	logic [RW-1:0]  ram_wdata;
	logic [RW-1:0]  ram_rdata;
	logic           ent_valid;
	logic [31:0]    ent_value;

	assign ent_valid = ram_rdata[RW-1];
	assign ent_value = ram_rdata[31:0];

	// Entry store: {valid, value}
	smt_ram #(
		.WIDTH(RW),
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req;
		end
	end

	// Scan / clear address counter and read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			if (cmd.load_req) begin
				scan_cnt_q <= '0;
			end else if (cmd.scan_issue || cmd.clear_wr) begin
				scan_cnt_q <= scan_cnt_q + CW'(1);
			end
			rd_vld_s1 <= cmd.scan_issue;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_cnt_q[AW-1:0];
	end

	// Match and free-slot tracking over the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
		end else if (cmd.load_req) begin
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
		end else if (rd_vld_s1) begin
			if (ent_valid && ent_value == req_q.element) begin
				hit_q <= 1'b1;
			end
			if (!ent_valid && !free_found_q) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1 && ent_valid && ent_value == req_q.element) begin
			hit_idx_q <= rd_idx_s1;
		end
		if (rd_vld_s1 && !ent_valid && !free_found_q) begin
			free_idx_q <= rd_idx_s1;
		end
	end

	// Outcome of the request and store update
	always_comb begin
		status_d  = STAT_MISS;
		count_d   = count_q;
		ram_we    = 1'b0;
		ram_addr  = scan_cnt_q[AW-1:0];
		ram_wdata = '0;
		if (cmd.clear_wr) begin
			ram_we = 1'b1;
		end
		case (req_q.opcode)
			OP_ADD: begin
				if (hit_q) begin
					status_d = STAT_MISS;
				end else if (free_found_q) begin
					status_d = STAT_OK;
					count_d  = count_q + CW'(1);
					if (cmd.commit) begin
						ram_we    = 1'b1;
						ram_addr  = free_idx_q;
						ram_wdata = {1'b1, req_q.element};
					end
				end else begin
					status_d = STAT_FULL;
				end
			end
			OP_REMOVE: begin
				if (hit_q) begin
					status_d = STAT_OK;
					count_d  = count_q - CW'(1);
					if (cmd.commit) begin
						ram_we   = 1'b1;
						ram_addr = hit_idx_q;
					end
				end
			end
			OP_SEARCH: begin
				status_d = hit_q ? STAT_OK : STAT_MISS;
			end
			default: begin
				status_d = STAT_MISS;
			end
		endcase
	end

	assign count_ext = CWX'(count_d);

	// Element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.commit) begin
			out_vld_q <= 1'b1;
		end else if (rsp_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q.status    <= status_d;
			rsp_q.count     <= count_ext[4:0];
			rsp_q.empty_res <= (count_d == '0);
		end
	end

	assign rsp_valid      = out_vld_q;
	assign rsp            = rsp_q;
	assign sts.issue_done = (scan_cnt_q == CW'(CAPACITY));
	assign sts.rd_pend    = rd_vld_s1;
	assign sts.out_free   = !out_vld_q || rsp_ready;

endmodule

FILE: design/set_membership_table_top.sv
`timescale 1ns / 1ps

// Bounded set of up to CAPACITY distinct 32-bit elements.
// Request channel (req_valid/req_ready/req): opcode add, remove or search
// plus an element. Response channel (rsp_valid/rsp_ready/rsp): status,
// element count after the request and an empty flag; one response for
// each request, in order.
// Each request walks the whole entry RAM, one entry a cycle through its
// single registered-read port, then commits once the output register
// is free. Requests are taken one at a time; the next is taken only
// after the previous one has committed. Add takes the lowest free slot.
// After reset a clearing pass zeroes every entry; req_ready stays low
// until it is done.
// The response sits in an output register; the next request is still
// taken and scanned while it waits, but its commit holds until the
// previous response is taken.

module set_membership_table_top #(
	parameter int CAPACITY = smt_pkg::DEFAULT_CAPACITY
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  smt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output smt_pkg::rsp_t rsp
);

	import smt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Controller
	smt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath
	smt_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	// Checks
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.out_free)
		else $error("commit while response register still occupied");

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_req, cmd.scan_issue, cmd.clear_wr, cmd.commit}))
		else $error("more than one datapath command at once");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (CAPACITY > 31) || (rsp.empty_res == (rsp.count == 5'd0)))
		else $error("empty flag disagrees with count");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == STAT_FULL) |->
		(CAPACITY > 31) || (rsp.count == 5'(CAPACITY)))
		else $error("full status below capacity");

endmodule

FILE: bench/set_membership_table_top_tb.sv
`timescale 1ns / 1ps

module set_membership_table_top_tb;
	import smt_pkg::*;

	localparam int SET_CAP = DEFAULT_CAPACITY;
	localparam int RAND_ITEMS = 950;
	localparam int POOL_SIZE = 20;
	localparam int LONG_HOLD = 300;
	localparam int HOLD_AT = 200;
	localparam int PAUSE_AT = 500;
	localparam int TAIL_ITEMS = 80;
	localparam int SETTLE_CYCLES = 2 * SET_CAP + 8;

	// Opcode that the block leaves undefined
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		req_t r;
		bit   typed;
		rsp_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// Shadow copy of the set
	logic [31:0] set_value [SET_CAP];
	bit          set_used [SET_CAP];
	int          set_count = 0;

	rsp_t expected_rsp_q [$];
	int   mismatch_cnt = 0;
	int   rsp_seen = 0;
	bit   hold_req = 1'b0;
	bit   tail_quiet = 1'b0;
	rsp_t want_rsp;

	set_membership_table_top #(.CAPACITY(SET_CAP)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Set behavior: update the shadow set, return the response it implies
	function automatic rsp_t apply_membership(input req_t r);
		int   hit;
		int   free_idx;
		rsp_t o;
		hit = -1;
		free_idx = -1;
		for (int i = 0; i < SET_CAP; i++) begin
			if (set_used[i] && set_value[i] == r.element && hit < 0)
				hit = i;
			if (!set_used[i] && free_idx < 0)
				free_idx = i;
		end
		o.status = STAT_MISS;
		case (r.opcode)
			OP_ADD: begin
				if (hit < 0) begin
					if (free_idx < 0 || set_count >= SET_CAP) begin
						o.status = STAT_FULL;
					end else begin
						set_value[free_idx] = r.element;
						set_used[free_idx] = 1'b1;
						set_count++;
						o.status = STAT_OK;
					end
				end
			end
			OP_REMOVE: begin
				if (hit >= 0) begin
					set_used[hit] = 1'b0;
					set_count--;
					o.status = STAT_OK;
				end
			end
			OP_SEARCH: begin
				if (hit >= 0)
					o.status = STAT_OK;
			end
			default: ;
		endcase
		o.count = 5'(set_count);
		o.empty_res = (set_count == 0);
		return o;
	endfunction

	function automatic dir_row_t typed_row(input logic [1:0] op, input logic [31:0] elem,
		input logic [1:0] st, input int cnt);
		dir_row_t d;
		d.r.opcode = op;
		d.r.element = elem;
		d.typed = 1'b1;
		d.want.status = st;
		d.want.count = 5'(cnt);
		d.want.empty_res = (cnt == 0);
		return d;
	endfunction

	function automatic dir_row_t plain_row(input logic [1:0] op, input logic [31:0] elem);
		dir_row_t d;
		d.r.opcode = op;
		d.r.element = elem;
		d.typed = 1'b0;
		d.want = '0;
		return d;
	endfunction

	// Offer one request, hold it until taken, then log what should come back
	task automatic issue(input req_t r, input bit typed, input rsp_t want, input int idle_pct);
		rsp_t pred;
		int   gap;
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		pred = apply_membership(r);
		expected_rsp_q.push_back(typed ? want : pred);
		if ($urandom_range(0, 99) < idle_pct) begin
			req_valid <= 1'b0;
			gap = $urandom_range(1, 17);
			repeat (gap) @(posedge clk);
		end
	endtask

	// Response checker
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			rsp_seen <= rsp_seen + 1;
			if (expected_rsp_q.size() == 0) begin
				mismatch_cnt <= mismatch_cnt + 1;
				if (mismatch_cnt < 10)
					$display("response %0d: none expected, got status %0d count %0d empty %0d",
						rsp_seen, rsp.status, rsp.count, rsp.empty_res);
			end else begin
				want_rsp = expected_rsp_q.pop_front();
				if (rsp.status !== want_rsp.status || rsp.count !== want_rsp.count ||
					rsp.empty_res !== want_rsp.empty_res) begin
					mismatch_cnt <= mismatch_cnt + 1;
					if (mismatch_cnt < 10)
						$display("response %0d: expected status %0d count %0d empty %0d, got status %0d count %0d empty %0d",
							rsp_seen, want_rsp.status, want_rsp.count, want_rsp.empty_res,
							rsp.status, rsp.count, rsp.empty_res);
				end
			end
		end
	end

	// Response side: random stalls, one long hold-off, steady at the tail
	initial begin : receiver
		int  burst;
		int  idle_pct;
		int  span;
		bit  hold_done;
		idle_pct = 0;
		span = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (span == 0) begin
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 8;
					default: idle_pct = 25;
				endcase
				span = 256;
			end
			span--;
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				rsp_ready <= 1'b1;
			end else if (!tail_quiet && $urandom_range(0, 99) < idle_pct) begin
				rsp_ready <= 1'b0;
				burst = $urandom_range(1, 17);
				repeat (burst) @(posedge clk);
				rsp_ready <= 1'b1;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Request side: directed table, then random traffic
	initial begin : stimulus
		dir_row_t    dir_rows [$];
		logic [31:0] elem_pool [POOL_SIZE];
		req_t        r;
		rsp_t        none;
		int          idle_pct;
		int          pick;
		int          k;
		bit          filling;

		none = '0;
		for (int i = 0; i < SET_CAP; i++) begin
			set_value[i] = '0;
			set_used[i] = 1'b0;
		end
		for (int i = 0; i < POOL_SIZE; i++)
			elem_pool[i] = $urandom;

		// Empty set, extremes, duplicates, full table
		dir_rows.push_back(typed_row(OP_SEARCH, 32'h0000_0000, STAT_MISS, 0));
		dir_rows.push_back(typed_row(OP_REMOVE, 32'h7FFF_FFFF, STAT_MISS, 0));
		dir_rows.push_back(typed_row(OP_UNUSED, 32'h0000_0000, STAT_MISS, 0));
		dir_rows.push_back(typed_row(OP_ADD, 32'h8000_0000, STAT_OK, 1));
		dir_rows.push_back(typed_row(OP_ADD, 32'h8000_0000, STAT_MISS, 1));
		dir_rows.push_back(typed_row(OP_SEARCH, 32'h8000_0000, STAT_OK, 1));
		dir_rows.push_back(typed_row(OP_ADD, 32'h7FFF_FFFF, STAT_OK, 2));
		dir_rows.push_back(typed_row(OP_ADD, 32'h0000_0000, STAT_OK, 3));
		dir_rows.push_back(typed_row(OP_ADD, 32'hFFFF_FFFF, STAT_OK, 4));
		dir_rows.push_back(typed_row(OP_REMOVE, 32'h0000_0000, STAT_OK, 3));
		dir_rows.push_back(typed_row(OP_SEARCH, 32'h0000_0000, STAT_MISS, 3));
		for (int i = 0; i < SET_CAP - 3; i++)
			dir_rows.push_back(plain_row(OP_ADD, 32'h0101_0101 * (i + 1)));
		dir_rows.push_back(typed_row(OP_ADD, 32'h5555_5555, STAT_FULL, SET_CAP));
		dir_rows.push_back(typed_row(OP_UNUSED, 32'hAAAA_AAAA, STAT_MISS, SET_CAP));
		dir_rows.push_back(typed_row(OP_ADD, 32'h7FFF_FFFF, STAT_MISS, SET_CAP));

		wait (arst_n === 1'b1);
		@(posedge clk);
		foreach (dir_rows[i])
			issue(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].want, 20);

		idle_pct = 0;
		filling = 1'b0;
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 100 == 0) begin
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 10;
					default: idle_pct = 35;
				endcase
			end
			if (n % 48 == 0)
				filling = !filling;
			if (n == HOLD_AT)
				hold_req = 1'b1;
			// let everything drain before going on
			if (n == PAUSE_AT) begin
				req_valid <= 1'b0;
				while (expected_rsp_q.size() != 0) @(posedge clk);
				@(posedge clk);
			end
			if (n >= RAND_ITEMS - TAIL_ITEMS) begin
				tail_quiet = 1'b1;
				idle_pct = 0;
			end

			// operation mix leans toward filling or draining the set
			pick = $urandom_range(0, 99);
			if (filling)
				r.opcode = (pick < 55) ? OP_ADD : (pick < 70) ? OP_REMOVE :
					(pick < 90) ? OP_SEARCH : OP_UNUSED;
			else
				r.opcode = (pick < 15) ? OP_ADD : (pick < 70) ? OP_REMOVE :
					(pick < 90) ? OP_SEARCH : OP_UNUSED;

			// element: a stored one, one from a small pool, or anything
			pick = $urandom_range(0, 99);
			if (pick < 45 && set_count > 0) begin
				do k = $urandom_range(0, SET_CAP - 1); while (!set_used[k]);
				r.element = set_value[k];
			end else if (pick < 80) begin
				r.element = elem_pool[$urandom_range(0, POOL_SIZE - 1)];
			end else begin
				r.element = $urandom;
			end
			issue(r, 1'b0, none, idle_pct);
		end
		req_valid <= 1'b0;

		while (expected_rsp_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && expected_rsp_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Hang guard
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
